/* hdl/wcp_pkg.sv */
// ---------------------------------------------------------------------------
// wcp_pkg
// Shared types and constants of the write coalescing planner.
// ---------------------------------------------------------------------------
package wcp_pkg;

    localparam int OFF_W     = 48;
    localparam int SIZE_W    = 32;
    localparam int SUM_W     = 38;
    localparam int BURST_W   = 37;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_BOUNDED   = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        CMD_FLUSH  = 1'b0,
        CMD_SINGLE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   last;
        logic                   bank;
        logic [CNT_W-1:0]       count;
        logic [OFF_W-1:0]       offset;
        logic [SUM_W-1:0]       size;
        logic                   err;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } flush_done_t;

endpackage

/* hdl/wcp_ram.sv */
// ---------------------------------------------------------------------------
// wcp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/wcp_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// wcp_cmd_fifo
// Four-entry command queue between the front end and the burst engine.
// ---------------------------------------------------------------------------
module wcp_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wcp_pkg::cmd_t push_cmd,
    input  logic          pop,
    output wcp_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import wcp_pkg::*;

    cmd_t       entry_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] fill_reg, fill_next;

    assign full  = (fill_reg == 3'd4);
    assign empty = (fill_reg == 3'd0);
    assign head  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 2'd1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 2'd1 : rptr_reg;
        fill_next = fill_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/wcp_front.sv */
// ---------------------------------------------------------------------------
// wcp_front
// Accepts write descriptors, checks contiguity, keeps the run and issues
// flush and single-burst commands.
// ---------------------------------------------------------------------------
module wcp_front #(
    parameter int RUN_DEPTH = 32,
    localparam int IW       = $clog2(RUN_DEPTH),
    localparam int CW       = $clog2(RUN_DEPTH + 1),
    localparam int AW       = IW + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wcp_pkg::SIZE_W-1:0]   wr_size,
    input  logic [wcp_pkg::OFF_W-1:0]    wr_offset,
    input  logic                         batch_end,
    input  logic [wcp_pkg::SIZE_W-1:0]   threshold,
    input  logic                         bounded,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [wcp_pkg::SIZE_W-1:0]   ram_wdata,
    output logic                         push,
    output wcp_pkg::cmd_t                push_cmd,
    input  logic                         fifo_full,
    input  wcp_pkg::flush_done_t         done
);
    import wcp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_PUSH_A, S_PUSH_B} state_t;

    state_t             state_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               end_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [OFF_W-1:0]   run_off_reg, run_off_next;
    logic [OFF_W-1:0]   exp_reg, exp_next;
    logic               bank_reg, bank_next;
    logic [1:0]         busy_reg, busy_set;
    cmd_t               cmd_a_reg, cmd_a_next;
    cmd_t               cmd_b_reg, cmd_b_next;
    logic               has_a_next;
    logic               has_b_reg, has_b_next;

    logic               wr_need;
    logic               bank_e;
    logic [CW-1:0]      cnt_e;
    logic [SUM_W-1:0]   total_plus;
    logic               pre;
    logic               post;
    logic               eval_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign ram_wdata = size_reg;
    assign ram_we    = wr_need && eval_go;
    assign eval_go   = (state_reg == S_EVAL) && !(wr_need && busy_reg[bank_e]);

    always_comb
    begin
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        run_off_next = run_off_reg;
        exp_next     = exp_reg;
        bank_next    = bank_reg;
        busy_set     = '0;
        has_a_next   = 1'b0;
        has_b_next   = 1'b0;
        cmd_a_next   = '{CMD_FLUSH, 1'b0, bank_reg, CNT_W'(cnt_reg), run_off_reg,
                         total_reg, 1'b0};
        cmd_b_next   = cmd_a_next;
        wr_need      = 1'b0;
        bank_e       = bank_reg;
        cnt_e        = cnt_reg;
        pre          = 1'b0;
        post         = 1'b0;
        total_plus   = total_reg + SUM_W'(size_reg);
        ram_waddr    = '0;

        if (size_reg != '0)
        begin
            exp_next = off_reg + OFF_W'(size_reg);
            if ((off_reg != exp_reg) || (size_reg >= threshold))
            begin
                if (cnt_reg != '0)
                begin
                    has_a_next         = 1'b1;
                    busy_set[bank_reg] = 1'b1;
                    bank_next          = ~bank_reg;
                end
                has_b_next = 1'b1;
                cmd_b_next = '{CMD_SINGLE, 1'b0, bank_reg,
                               (off_reg != exp_reg) ? CNT_W'(0) : CNT_W'(1),
                               off_reg, SUM_W'(size_reg), off_reg != exp_reg};
                cnt_next   = '0;
                total_next = '0;
            end
            else
            begin
                pre = (cnt_reg != '0) && ((cnt_reg >= CW'(RUN_DEPTH)) ||
                      (bounded && (total_plus > SUM_W'(threshold))));
                if (pre)
                begin
                    has_a_next         = 1'b1;
                    busy_set[bank_reg] = 1'b1;
                    bank_e             = ~bank_reg;
                    cnt_e              = '0;
                end
                if (cnt_e == '0)
                begin
                    run_off_next = off_reg;
                end
                wr_need    = 1'b1;
                ram_waddr  = {bank_e, cnt_e[IW-1:0]};
                cnt_next   = cnt_e + CW'(1);
                total_next = pre ? SUM_W'(size_reg) : total_plus;
                bank_next  = bank_e;
                post = (cnt_next >= CW'(RUN_DEPTH)) ||
                       (bounded && (total_next >= SUM_W'(threshold)));
            end
        end

        if ((post || end_reg) && (cnt_next != '0))
        begin
            has_b_next          = 1'b1;
            cmd_b_next          = '{CMD_FLUSH, 1'b0, bank_next, CNT_W'(cnt_next),
                                    run_off_next, total_next, 1'b0};
            busy_set[bank_next] = 1'b1;
            bank_next           = ~bank_next;
            cnt_next            = '0;
            total_next          = '0;
        end

        if (has_b_next)
        begin
            cmd_b_next.last = 1'b1;
        end
        else
        begin
            cmd_a_next.last = 1'b1;
        end
    end

    always_comb
    begin
        push     = 1'b0;
        push_cmd = cmd_a_reg;
        unique case (state_reg)
            S_PUSH_A:
            begin
                push     = !fifo_full;
                push_cmd = cmd_a_reg;
            end
            S_PUSH_B:
            begin
                push     = !fifo_full;
                push_cmd = cmd_b_reg;
            end
            S_IDLE, S_EVAL:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            run_off_reg <= '0;
            exp_reg     <= '0;
            bank_reg    <= 1'b0;
            busy_reg    <= '0;
            has_b_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= (busy_reg & ~({1'b0, done.valid} << done.bank)) |
                        (eval_go ? busy_set : 2'b00);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (eval_go)
                    begin
                        cnt_reg     <= cnt_next;
                        total_reg   <= total_next;
                        run_off_reg <= run_off_next;
                        exp_reg     <= exp_next;
                        bank_reg    <= bank_next;
                        has_b_reg   <= has_b_next;
                        if (has_a_next)
                        begin
                            state_reg <= S_PUSH_A;
                        end
                        else if (has_b_next)
                        begin
                            state_reg <= S_PUSH_B;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_PUSH_A:
                begin
                    if (!fifo_full)
                    begin
                        state_reg <= has_b_reg ? S_PUSH_B : S_IDLE;
                    end
                end
                S_PUSH_B:
                begin
                    if (!fifo_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            size_reg <= wr_size;
            off_reg  <= wr_offset;
            end_reg  <= batch_end;
        end
        if (eval_go)
        begin
            cmd_a_reg <= cmd_a_next;
            cmd_b_reg <= cmd_b_next;
        end
    end

endmodule

/* hdl/wcp_back.sv */
// ---------------------------------------------------------------------------
// wcp_back
// Burst engine: walks a buffered run, cuts it into bursts and drives the
// result register.
// ---------------------------------------------------------------------------
module wcp_back #(
    parameter int RUN_DEPTH = 32,
    localparam int IW       = $clog2(RUN_DEPTH),
    localparam int CW       = $clog2(RUN_DEPTH + 1),
    localparam int AW       = IW + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wcp_pkg::SIZE_W-1:0]    threshold,
    input  logic                          bounded,
    input  logic                          fifo_empty,
    input  wcp_pkg::cmd_t                 fifo_head,
    output logic                          pop,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [wcp_pkg::SIZE_W-1:0]    ram_rdata,
    output wcp_pkg::flush_done_t          done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wcp_pkg::OFF_W-1:0]     burst_offset,
    output logic [wcp_pkg::BURST_W-1:0]   burst_size,
    output logic [wcp_pkg::CNT_W-1:0]     merged_count,
    output logic                          error_code,
    output logic                          is_last
);
    import wcp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_ACC, S_EMIT} state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [CW-1:0]       idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    grp_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic                fin_reg;
    logic                out_valid_reg;
    logic [OFF_W-1:0]    out_off_reg;
    logic [BURST_W-1:0]  out_size_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic                out_err_reg;
    logic                out_last_reg;
    flush_done_t         done_reg;

    logic [SUM_W-1:0]    sum_plus;
    logic [SUM_W-1:0]    left_bytes;
    logic [CW-1:0]       idx_plus;
    logic                take;
    logic                cut;
    logic                load;

    assign pop          = (state_reg == S_IDLE) && !fifo_empty;
    assign ram_raddr    = {cmd_reg.bank, idx_reg[IW-1:0]};
    assign load         = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign done         = done_reg;
    assign out_valid    = out_valid_reg;
    assign burst_offset = out_off_reg;
    assign burst_size   = out_size_reg;
    assign merged_count = out_cnt_reg;
    assign error_code   = out_err_reg;
    assign is_last      = out_last_reg;

    always_comb
    begin
        sum_plus   = sum_reg + SUM_W'(ram_rdata);
        idx_plus   = idx_reg + CW'(1);
        left_bytes = rem_reg - sum_plus;
        take       = (grp_reg == '0) || (sum_plus <= SUM_W'(threshold));
        cut        = (idx_plus == CW'(cmd_reg.count)) ||
                     ((sum_plus >= SUM_W'(threshold)) &&
                      ((left_bytes == '0) || (left_bytes >= SUM_W'(threshold))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            done_reg <= '{load && fin_reg && (cmd_reg.kind == CMD_FLUSH), cmd_reg.bank};
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!fifo_empty)
                    begin
                        state_reg <= (fifo_head.kind == CMD_SINGLE) ? S_EMIT : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (bounded)
                    begin
                        state_reg <= (take && (idx_plus != CW'(cmd_reg.count)))
                                     ? S_READ : S_EMIT;
                    end
                    else
                    begin
                        state_reg <= cut ? S_EMIT : S_READ;
                    end
                end
                S_EMIT:
                begin
                    if (load)
                    begin
                        state_reg <= fin_reg ? S_IDLE : S_READ;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_off_reg  <= off_reg;
            out_size_reg <= sum_reg[BURST_W-1:0];
            out_cnt_reg  <= grp_reg;
            out_err_reg  <= cmd_reg.err;
            out_last_reg <= cmd_reg.last && fin_reg;
            off_reg      <= off_reg + OFF_W'(sum_reg);
            rem_reg      <= rem_reg - sum_reg;
            sum_reg      <= '0;
            grp_reg      <= '0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= fifo_head;
                idx_reg <= '0;
                off_reg <= fifo_head.offset;
                rem_reg <= fifo_head.size;
                fin_reg <= 1'b1;
                if (fifo_head.kind == CMD_SINGLE)
                begin
                    sum_reg <= fifo_head.size;
                    grp_reg <= fifo_head.count;
                end
                else
                begin
                    sum_reg <= '0;
                    grp_reg <= '0;
                end
            end
            S_ACC:
            begin
                if (!bounded || take)
                begin
                    sum_reg <= sum_plus;
                    idx_reg <= idx_plus;
                    grp_reg <= grp_reg + CNT_W'(1);
                    fin_reg <= (idx_plus == CW'(cmd_reg.count));
                end
                else
                begin
                    fin_reg <= 1'b0;
                end
            end
            S_READ, S_EMIT:
            begin
                fin_reg <= fin_reg;
            end
        endcase
    end

endmodule

/* hdl/write_coalescing_planner.sv */
// ---------------------------------------------------------------------------
// write_coalescing_planner
// Turns contiguous write descriptors into physical write bursts.
// ---------------------------------------------------------------------------
// A descriptor takes the front end's idle and evaluate states, then a push
// state per command it issues (a flush of the buffered run and/or a single
// burst), waiting while the four-entry command queue is full. The burst engine
// takes each command in its idle state, walks each buffered write of a
// flushed run through a read and an accumulate state, and emits bursts when
// the output register is free; in bounded mode the write that would overflow
// a burst is read again for the next burst. The run buffer has two banks; the
// front end waits only when it must write into a bank whose flush is still
// being walked. No clearing pass follows reset.
module write_coalescing_planner #(
    parameter int RUN_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [wcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wcp_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [wcp_pkg::SIZE_W-1:0]         wr_size,
    input  logic [wcp_pkg::OFF_W-1:0]          wr_offset,
    input  logic                               batch_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [wcp_pkg::OFF_W-1:0]          burst_offset,
    output logic [wcp_pkg::BURST_W-1:0]        burst_size,
    output logic [wcp_pkg::CNT_W-1:0]          merged_count,
    output logic                               error_code,
    output logic                               is_last
);
    import wcp_pkg::*;

    localparam int AW = $clog2(RUN_DEPTH) + 1;

    logic [SIZE_W-1:0] threshold_reg;
    logic              bounded_reg;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [SIZE_W-1:0] ram_rdata;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    cmd_t              head;
    logic              fifo_full;
    logic              fifo_empty;
    flush_done_t       done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            bounded_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: threshold_reg <= cfg_data[SIZE_W-1:0];
                CFG_BOUNDED:   bounded_reg   <= cfg_data[0];
            endcase
        end
    end

    wcp_front #(.RUN_DEPTH(RUN_DEPTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .wr_size      (wr_size),
        .wr_offset    (wr_offset),
        .batch_end    (batch_end),
        .threshold    (threshold_reg),
        .bounded      (bounded_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .push         (push),
        .push_cmd     (push_cmd),
        .fifo_full    (fifo_full),
        .done         (done)
    );

    wcp_ram #(.WIDTH(SIZE_W), .DEPTH(2 ** AW)) u_run_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wcp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    wcp_back #(.RUN_DEPTH(RUN_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold    (threshold_reg),
        .bounded      (bounded_reg),
        .fifo_empty   (fifo_empty),
        .fifo_head    (head),
        .pop          (pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .burst_offset (burst_offset),
        .burst_size   (burst_size),
        .merged_count (merged_count),
        .error_code   (error_code),
        .is_last      (is_last)
    );

`ifndef SYNTH
    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code |-> merged_count == '0)
        else $error("error burst with nonzero merged count");

    a_ok_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error_code |-> merged_count != '0 && burst_size != '0)
        else $error("empty burst transfer");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("command queue overflow");
`endif

endmodule
